[hw/rtl/gateway_table_least_loaded_select_unit_defines.svh]
// ----------------------------------------------------------------------------
// Gateway table least-loaded select unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef GATEWAY_TABLE_LEAST_LOADED_SELECT_UNIT_DEFINES_SVH
`define GATEWAY_TABLE_LEAST_LOADED_SELECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GTLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtls assertion failed");

// Next-cycle implication, disabled in reset.
`define GTLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtls assertion failed");

`endif

[hw/rtl/gtls_pkg.sv]
// ----------------------------------------------------------------------------
// gtls_pkg
// Types, codes and constants of the gateway table least-loaded select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gtls_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int TOTAL_W         = 22;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] GW_ACTIVE = 2'd0;
    localparam logic [1:0] GW_MAINT  = 2'd1;

    typedef enum logic [1:0] {
        FUNC_PUT     = 2'd0,
        FUNC_DISABLE = 2'd1,
        FUNC_SELECT  = 2'd2,
        FUNC_TOTAL   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_GW   = 2'd1,
        ST_VERSION = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] zone;
        logic [15:0] server_id;
        logic [31:0] ip_addr;
        logic [15:0] port;
        logic [15:0] online_count;
        logic [1:0]  gw_state;
        logic [31:0] zone_version;
        logic [31:0] client_version;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [15:0]        sel_server_id;
        logic [31:0]        sel_ip_addr;
        logic [15:0]        sel_port;
        logic [15:0]        sel_online;
        logic [TOTAL_W-1:0] total_online;
    } rsp_beat_t;

    typedef struct packed {
        logic [31:0] zone;
        logic [15:0] server;
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] online;
        logic [1:0]  state;
        logic [31:0] version;
    } entry_t;

    // Control from the sequencer to the evaluation unit.
    typedef struct packed {
        logic        start;
        logic        beat;
        logic [31:0] zone;
        logic [15:0] server_id;
    } eval_ctl_t;

    // Accumulated results of one sweep, plus the zone hit of the current beat.
    typedef struct packed {
        logic               hit;
        logic               have;
        logic               match;
        entry_t             best;
        logic [TOTAL_W-1:0] total;
    } eval_res_t;

endpackage

`default_nettype wire

[hw/rtl/gtls_stream_if.sv]
// ----------------------------------------------------------------------------
// gtls_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtls_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/gtls_entry_mem.sv]
// ----------------------------------------------------------------------------
// gtls_entry_mem
// Gateway entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtls_entry_mem #(
    parameter int DEPTH = gtls_pkg::ENTRIES_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire gtls_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output gtls_pkg::entry_t     rd_data
);

    gtls_pkg::entry_t mem [DEPTH];
    gtls_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/gtls_eval.sv]
// ----------------------------------------------------------------------------
// gtls_eval
// Per-beat evaluation of swept entries: least-loaded pick, put match, total.
// ----------------------------------------------------------------------------
`default_nettype none

module gtls_eval #(
    parameter int AW = $clog2(gtls_pkg::ENTRIES_DEFAULT)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gtls_pkg::eval_ctl_t ctl,
    input  wire logic [AW-1:0]      idx,
    input  wire gtls_pkg::entry_t   rd,
    output gtls_pkg::eval_res_t     res,
    output logic [AW-1:0]           match_idx
);

    logic                        have_reg, have_next;
    logic                        match_reg, match_next;
    gtls_pkg::entry_t            best_reg, best_next;
    logic [AW-1:0]               match_idx_reg, match_idx_next;
    logic [gtls_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [gtls_pkg::TOTAL_W:0]  sum_wide;
    logic                        hit;
    logic                        take;

    assign hit  = ctl.beat && (rd.zone == ctl.zone);
    // later slot wins a tie: >= keeps replacing
    assign take = hit && (rd.state == gtls_pkg::GW_ACTIVE)
                  && (!have_reg || (best_reg.online >= rd.online));
    assign sum_wide = {1'b0, total_reg} + (gtls_pkg::TOTAL_W+1)'(rd.online);

    always_comb
    begin
        have_next      = have_reg;
        match_next     = match_reg;
        best_next      = best_reg;
        match_idx_next = match_idx_reg;
        total_next     = total_reg;
        if (ctl.start)
        begin
            have_next  = 1'b0;
            match_next = 1'b0;
            total_next = '0;
        end
        else if (ctl.beat)
        begin
            if (take)
            begin
                have_next = 1'b1;
                best_next = rd;
            end
            // keep the first matching slot
            if (hit && (rd.server == ctl.server_id) && !match_reg)
            begin
                match_next     = 1'b1;
                match_idx_next = idx;
            end
            if (sum_wide > (gtls_pkg::TOTAL_W+1)'(gtls_pkg::TOTAL_MAX))
            begin
                total_next = gtls_pkg::TOTAL_MAX;
            end
            else
            begin
                total_next = sum_wide[gtls_pkg::TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            match_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            have_reg  <= have_next;
            match_reg <= match_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        match_idx_reg <= match_idx_next;
    end

    assign res.hit   = hit;
    assign res.have  = have_reg;
    assign res.match = match_reg;
    assign res.best  = best_reg;
    assign res.total = total_reg;
    assign match_idx = match_idx_reg;

endmodule

`default_nettype wire

[hw/rtl/gateway_table_least_loaded_select_unit.sv]
// An accepted item sweeps the filled slots through the single read port of the
//   entry memory (S_SCAN, then S_DRAIN) and S_FINISH loads its result; an empty
//   table skips the sweep. A new item is taken only once that result is loaded.
// A finished result waits in the output register while the next item is taken.
// Reset: fill count and handshake state clear at once; entry contents stay
//   undefined and need no clearing pass, since only filled slots are read.
// ----------------------------------------------------------------------------
// gateway_table_least_loaded_select_unit
// Zone-tagged gateway table with put, zone disable, least-loaded select and
// total online count, built around one synchronous entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

module gateway_table_least_loaded_select_unit #(
    parameter int ENTRIES = gtls_pkg::ENTRIES_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    gtls_stream_if.sink    req,
    gtls_stream_if.source  rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          addr_reg, addr_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          addr_inc;
    gtls_pkg::req_beat_t    cmd_reg, cmd_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   out_valid_reg, out_valid_next;
    gtls_pkg::rsp_beat_t    out_data_reg, out_data_next;

    logic                   accept;
    logic                   load;
    logic                   rd_en;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    gtls_pkg::entry_t       wr_data;
    gtls_pkg::entry_t       rd_data;
    gtls_pkg::entry_t       put_entry;
    gtls_pkg::eval_ctl_t    ctl;
    gtls_pkg::eval_res_t    res;
    logic [AW-1:0]          match_idx;
    logic                   table_full;
    gtls_pkg::func_t        func;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load      = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    assign addr_inc  = addr_reg + CW'(1);
    assign rd_en     = (state_reg == S_SCAN);
    assign func      = gtls_pkg::func_t'(cmd_reg.func);
    assign table_full = (fill_reg == CW'(ENTRIES));

    assign ctl.start     = accept;
    assign ctl.beat      = rd_valid_reg;
    assign ctl.zone      = cmd_reg.zone;
    assign ctl.server_id = cmd_reg.server_id;

    assign put_entry.zone    = cmd_reg.zone;
    assign put_entry.server  = cmd_reg.server_id;
    assign put_entry.ip      = cmd_reg.ip_addr;
    assign put_entry.port    = cmd_reg.port;
    assign put_entry.online  = cmd_reg.online_count;
    assign put_entry.state   = cmd_reg.gw_state;
    assign put_entry.version = cmd_reg.zone_version;

    gtls_entry_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    gtls_eval #(
        .AW (AW)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .idx       (rd_idx_reg),
        .rd        (rd_data),
        .res       (res),
        .match_idx (match_idx)
    );

    // Write port: disable writes back each hit during the sweep, put writes at finish.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = rd_data;
        if (rd_valid_reg && (func == gtls_pkg::FUNC_DISABLE) && res.hit)
        begin
            wr_en        = 1'b1;
            wr_data.port   = '0;
            wr_data.online = '0;
            wr_data.state  = gtls_pkg::GW_MAINT;
        end
        else if (load && (func == gtls_pkg::FUNC_PUT))
        begin
            wr_data = put_entry;
            if (res.match)
            begin
                wr_en   = 1'b1;
                wr_addr = match_idx;
            end
            else if (!table_full)
            begin
                wr_en   = 1'b1;
                wr_addr = fill_reg[AW-1:0];
            end
        end
    end

    always_comb
    begin
        out_data_next = '0;
        unique case (func)
            gtls_pkg::FUNC_PUT:
            begin
                if (!res.match && table_full)
                begin
                    out_data_next.status = gtls_pkg::ST_FULL;
                end
            end
            gtls_pkg::FUNC_DISABLE:
            begin
                out_data_next.status = gtls_pkg::ST_OK;
            end
            gtls_pkg::FUNC_SELECT:
            begin
                if (!res.have)
                begin
                    out_data_next.status = gtls_pkg::ST_NO_GW;
                end
                else
                begin
                    out_data_next.found         = 1'b1;
                    out_data_next.sel_server_id = res.best.server;
                    out_data_next.sel_ip_addr   = res.best.ip;
                    out_data_next.sel_port      = res.best.port;
                    out_data_next.sel_online    = res.best.online;
                    if ((res.best.version != '0)
                        && (res.best.version != cmd_reg.client_version))
                    begin
                        out_data_next.status = gtls_pkg::ST_VERSION;
                    end
                end
            end
            gtls_pkg::FUNC_TOTAL:
            begin
                out_data_next.total_online = res.total;
            end
            default:
            begin
                out_data_next = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        fill_next      = fill_reg;
        cmd_next       = cmd_reg;
        rd_valid_next  = rd_en;
        rd_idx_next    = addr_reg[AW-1:0];
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = req.data;
                    addr_next = '0;
                    state_next = (fill_reg == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_inc;
                if (addr_inc == fill_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if ((func == gtls_pkg::FUNC_PUT) && !res.match && !table_full)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            fill_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            fill_reg      <= fill_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rd_idx_reg <= rd_idx_next;
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/gtls_checker.sv]
// ----------------------------------------------------------------------------
// gtls_checker
// Port-level checks of the gateway table least-loaded select unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gateway_table_least_loaded_select_unit_defines.svh"

module gtls_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_status,
    input wire logic        rsp_found,
    input wire logic [15:0] rsp_sel_online
);

    // result beat holds until taken
    `GTLS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // one item at a time: intake closes after each accepted beat
    `GTLS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    `GTLS_ASSERT_NOW(a_found_status, clk, rst_n, rsp_valid && rsp_found,
        (rsp_status == gtls_pkg::ST_OK) || (rsp_status == gtls_pkg::ST_VERSION))

    `GTLS_ASSERT_NOW(a_no_gw_empty, clk, rst_n,
        rsp_valid && (rsp_status == gtls_pkg::ST_NO_GW),
        !rsp_found && (rsp_sel_online == 16'd0))

endmodule

bind gateway_table_least_loaded_select_unit gtls_checker u_gtls_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.data.status),
    .rsp_found      (rsp.data.found),
    .rsp_sel_online (rsp.data.sel_online)
);

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: gateway table least-loaded select unit testbench
// Drives put, disable, select and total requests over the request channel and
// compares every response beat with a predicted table kept in a scoreboard.
// Both channels idle at random; the response side also holds off for a long
// stretch, and the request side pauses once until all responses are back.
// ----------------------------------------------------------------------------
module tb_top;

    import gtls_pkg::*;

    localparam int SLOTS        = ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 40;

    class least_loaded_scoreboard;
        bit          slot_used [SLOTS];
        entry_t      slot [SLOTS];
        int unsigned fill_count = 0;
        rsp_beat_t   expected_rsp [$];
        int unsigned mismatches = 0;

        function rsp_beat_t predict_response(req_beat_t r);
            rsp_beat_t   rsp;
            entry_t      fresh;
            bit          have;
            int unsigned best;
            logic [31:0] sum;
            rsp   = '0;
            fresh = '{zone: r.zone, server: r.server_id, ip: r.ip_addr, port: r.port,
                      online: r.online_count, state: r.gw_state,
                      version: r.zone_version};
            case (func_t'(r.func))
                FUNC_PUT: begin
                    have = 1'b0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!have && slot_used[i] && slot[i].zone == r.zone &&
                            slot[i].server == r.server_id) begin
                            slot[i] = fresh;
                            have    = 1'b1;
                        end
                    end
                    if (!have) begin
                        if (fill_count < SLOTS) begin
                            slot[fill_count]      = fresh;
                            slot_used[fill_count] = 1'b1;
                            fill_count++;
                        end else begin
                            rsp.status = ST_FULL;
                        end
                    end
                end
                FUNC_DISABLE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot[i].zone == r.zone) begin
                            slot[i].port   = '0;
                            slot[i].online = '0;
                            slot[i].state  = GW_MAINT;
                        end
                    end
                end
                FUNC_SELECT: begin
                    have = 1'b0;
                    best = 0;
                    // Ties go to the later slot.
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot[i].zone == r.zone &&
                            slot[i].state == GW_ACTIVE &&
                            (!have || slot[best].online >= slot[i].online)) begin
                            best = i;
                            have = 1'b1;
                        end
                    end
                    if (!have) begin
                        rsp.status = ST_NO_GW;
                    end else begin
                        rsp.found         = 1'b1;
                        rsp.sel_server_id = slot[best].server;
                        rsp.sel_ip_addr   = slot[best].ip;
                        rsp.sel_port      = slot[best].port;
                        rsp.sel_online    = slot[best].online;
                        if (slot[best].version != 0 && slot[best].version != r.client_version)
                            rsp.status = ST_VERSION;
                    end
                end
                default: begin
                    sum = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i]) begin
                            sum = sum + slot[i].online;
                            if (sum > TOTAL_MAX)
                                sum = TOTAL_MAX;
                        end
                    end
                    rsp.total_online = sum[TOTAL_W-1:0];
                end
            endcase
            return rsp;
        endfunction

        function void note_request(req_beat_t r);
            expected_rsp.push_back(predict_response(r));
        endfunction

        function int unsigned outstanding();
            return expected_rsp.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(rsp_beat_t got);
            rsp_beat_t want;
            if (expected_rsp.size() == 0) begin
                $display("%0t: response with none expected, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found", want.found, got.found);
            compare_field("sel_server_id", want.sel_server_id, got.sel_server_id);
            compare_field("sel_ip_addr", want.sel_ip_addr, got.sel_ip_addr);
            compare_field("sel_port", want.sel_port, got.sel_port);
            compare_field("sel_online", want.sel_online, got.sel_online);
            compare_field("total_online", want.total_online, got.total_online);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gtls_stream_if #(.T(req_beat_t)) req_if ();
    gtls_stream_if #(.T(rsp_beat_t)) rsp_if ();

    gateway_table_least_loaded_select_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    least_loaded_scoreboard board = new();

    logic [31:0] zone_pool [6];
    logic [31:0] version_pool [4];
    bit          hold_req;
    bit          quiet;
    int unsigned cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_beat_t make_item(func_t f, logic [31:0] zone, logic [15:0] sid,
                                            logic [31:0] ip, logic [15:0] port,
                                            logic [15:0] online, logic [1:0] st,
                                            logic [31:0] zver, logic [31:0] cver);
        req_beat_t b;
        b = '{func: f, zone: zone, server_id: sid, ip_addr: ip, port: port,
              online_count: online, gw_state: st, zone_version: zver,
              client_version: cver};
        return b;
    endfunction

    function automatic req_beat_t random_item();
        req_beat_t b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        b.func = (pick < 40) ? FUNC_PUT : (pick < 75) ? FUNC_SELECT :
                 (pick < 83) ? FUNC_DISABLE : FUNC_TOTAL;
        b.zone = ($urandom_range(0, 99) < 8) ? $urandom() : zone_pool[$urandom_range(0, 5)];
        pick = $urandom_range(0, 99);
        b.server_id = (pick < 85) ? 16'($urandom_range(0, 15)) :
                      (pick < 92) ? 16'hFFFF : 16'($urandom());
        b.ip_addr = $urandom();
        b.port    = 16'($urandom());
        // Small counts make ties common.
        b.online_count = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7))
                                                     : 16'($urandom());
        b.gw_state       = ($urandom_range(0, 99) < 75) ? GW_ACTIVE : 2'($urandom_range(1, 3));
        b.zone_version   = version_pool[$urandom_range(0, 3)];
        b.client_version = ($urandom_range(0, 9) == 0) ? $urandom()
                                                       : version_pool[$urandom_range(0, 3)];
        return b;
    endfunction

    task automatic drive_item(req_beat_t b);
        req_if.valid <= 1'b1;
        req_if.data  <= b;
        do @(posedge clk); while (!req_if.ready);
        board.note_request(b);
        if (!quiet && $urandom_range(0, 99) < 9)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Response side: check each beat, hold off once on request.
    initial
    begin : response_side
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                board.check_response(rsp_if.data);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (quiet)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= 9);
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        rsp_if.ready <= 1'b0;
        hold_req     <= 1'b0;
        quiet        <= 1'b0;
        zone_pool[0] = 32'h0;
        zone_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            zone_pool[i] = $urandom();
        version_pool[0] = 32'h0;
        version_pool[1] = 32'h1;
        version_pool[2] = $urandom();
        version_pool[3] = $urandom();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then field extremes, ties, refresh and version checks.
        drive_item(make_item(FUNC_TOTAL, '0, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_SELECT, '1, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_DISABLE, '1, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_PUT, '0, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_PUT, '1, '1, '1, '1, '1, 2'd3, '1, '1));
        drive_item(make_item(FUNC_PUT, '1, 16'd1, 32'h0A00_0001, 16'd80, '1, GW_ACTIVE,
                             '1, '0));
        drive_item(make_item(FUNC_PUT, '1, 16'd2, 32'h0A00_0002, 16'd81, '1, GW_ACTIVE,
                             '0, '0));
        drive_item(make_item(FUNC_SELECT, '1, '1, '1, '1, '1, 2'd3, '1, 32'd5));
        drive_item(make_item(FUNC_PUT, '1, 16'd2, 32'h0A00_0002, 16'd81, '1, GW_ACTIVE,
                             32'd7, '0));
        drive_item(make_item(FUNC_SELECT, '1, '0, '0, '0, '0, GW_ACTIVE, '0, 32'd5));
        drive_item(make_item(FUNC_SELECT, '1, '0, '0, '0, '0, GW_ACTIVE, '0, 32'd7));
        drive_item(make_item(FUNC_PUT, '0, 16'd3, 32'h1, 16'd2, 16'd1, 2'd2, '0, '0));
        drive_item(make_item(FUNC_SELECT, '0, '0, '0, '0, '0, GW_ACTIVE, '0, '1));
        drive_item(make_item(FUNC_TOTAL, '1, '1, '1, '1, '1, 2'd3, '1, '1));
        drive_item(make_item(FUNC_DISABLE, '1, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_SELECT, '1, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_TOTAL, '0, '0, '0, '0, '0, GW_ACTIVE, '0, '0));
        drive_item(make_item(FUNC_PUT, '1, 16'd1, 32'h0A00_0011, 16'd90, 16'd4, GW_ACTIVE,
                             '0, '0));
        drive_item(make_item(FUNC_SELECT, '1, '0, '0, '0, '0, GW_ACTIVE, '0, '0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 150)
                hold_req <= 1'b1;
            if (n == 400)
            begin
                // Hold the request side until every response is back.
                req_if.valid <= 1'b0;
                do @(posedge clk); while (board.outstanding() != 0);
            end
            if (n == 450)
                quiet <= 1'b1;
            if (n == 560)
                quiet <= 1'b0;
            drive_item(random_item());
        end

        req_if.valid <= 1'b0;
        do @(posedge clk); while (board.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
